/* rtl/core/bcp_pkg.sv */
// bcp_pkg: shared types and constants of the cascaded balance controller
// command codes, register indexes, reset values, controller-to-datapath command and status
// no dependencies
package bcp_pkg;

	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] CMD_RUN  = 2'd1;
	localparam logic [1:0] CMD_STOP = 2'd2;

	localparam logic [2:0] REG_BALANCE_ANGLE   = 3'd0;
	localparam logic [2:0] REG_VERTICAL_P_GAIN = 3'd1;
	localparam logic [2:0] REG_VERTICAL_D_GAIN = 3'd2;
	localparam logic [2:0] REG_SPEED_P_GAIN    = 3'd3;
	localparam logic [2:0] REG_SPEED_I_GAIN    = 3'd4;
	localparam logic [2:0] REG_TURN_P_GAIN     = 3'd5;
	localparam logic [2:0] REG_TURN_D_GAIN     = 3'd6;
	localparam logic [2:0] REG_TARGET_HEADING  = 3'd7;

	localparam logic signed [15:0] RST_BALANCE_ANGLE   = 16'sd0;
	localparam logic signed [31:0] RST_VERTICAL_P_GAIN = -32'sd22937600;
	localparam logic signed [31:0] RST_VERTICAL_D_GAIN = -32'sd66847;
	localparam logic signed [31:0] RST_SPEED_P_GAIN    = -32'sd16384;
	localparam logic signed [31:0] RST_SPEED_I_GAIN    = -32'sd82;
	localparam logic signed [31:0] RST_TURN_P_GAIN     = 32'sd655360;
	localparam logic signed [31:0] RST_TURN_D_GAIN     = 32'sd0;
	localparam logic signed [15:0] RST_TARGET_HEADING  = 16'sd0;

	typedef enum logic [2:0] {
		MUL_DIV = 3'd0,
		MUL_SP  = 3'd1,
		MUL_SI  = 3'd2,
		MUL_VP  = 3'd3,
		MUL_VD  = 3'd4,
		MUL_TP  = 3'd5,
		MUL_TD  = 3'd6
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2
	} acc_mode_t;

	typedef struct packed {
		logic      cap;
		logic      num_ld;
		logic      mul_en;
		mul_sel_t  mul_sel;
		acc_mode_t acc_mode;
		logic      fe_ld;
		logic      is_ld;
		logic      is_clr;
		logic      vel_ld;
		logic      diff_ld;
		logic      vert_ld;
		logic      turn_ld;
		logic      out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       out_free;
	} dp_status_t;

endpackage

/* rtl/core/bcp_ctrl.sv */
// bcp_ctrl: sequencer of the cascaded balance controller
// steps the shared multiply-accumulate datapath through one control tick
// depends on bcp_pkg
module bcp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output bcp_pkg::dp_cmd_t      cmd,
	input  bcp_pkg::dp_status_t   status
);

	typedef enum logic [15:0] {
		ST_IDLE = 16'h0001,
		ST_DEC  = 16'h0002,
		ST_DMUL = 16'h0004,
		ST_DFIX = 16'h0008,
		ST_INT  = 16'h0010,
		ST_M2   = 16'h0020,
		ST_VSUM = 16'h0040,
		ST_VEL  = 16'h0080,
		ST_DIFF = 16'h0100,
		ST_M3   = 16'h0200,
		ST_M4   = 16'h0400,
		ST_M5   = 16'h0800,
		ST_M6   = 16'h1000,
		ST_M7   = 16'h2000,
		ST_TURN = 16'h4000,
		ST_OUT  = 16'h8000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = bcp_pkg::MUL_DIV;
		cmd.acc_mode = bcp_pkg::ACC_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				cmd.num_ld = 1'b1;
				if (status.command == bcp_pkg::CMD_RUN) begin
					state_d = ST_DMUL;
				end else if (status.command == bcp_pkg::CMD_STOP) begin
					cmd.is_clr = 1'b1;
					state_d    = ST_OUT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = bcp_pkg::MUL_DIV;
				state_d     = ST_DFIX;
			end
			ST_DFIX: begin
				cmd.fe_ld = 1'b1;
				state_d   = ST_INT;
			end
			ST_INT: begin
				cmd.is_ld   = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = bcp_pkg::MUL_SP;
				state_d     = ST_M2;
			end
			ST_M2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = bcp_pkg::MUL_SI;
				cmd.acc_mode = bcp_pkg::ACC_LOAD;
				state_d      = ST_VSUM;
			end
			ST_VSUM: begin
				cmd.acc_mode = bcp_pkg::ACC_ADD;
				state_d      = ST_VEL;
			end
			ST_VEL: begin
				cmd.vel_ld = 1'b1;
				state_d    = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff_ld = 1'b1;
				state_d     = ST_M3;
			end
			ST_M3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = bcp_pkg::MUL_VP;
				state_d     = ST_M4;
			end
			ST_M4: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = bcp_pkg::MUL_VD;
				cmd.acc_mode = bcp_pkg::ACC_LOAD;
				state_d      = ST_M5;
			end
			ST_M5: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = bcp_pkg::MUL_TP;
				cmd.acc_mode = bcp_pkg::ACC_ADD;
				state_d      = ST_M6;
			end
			ST_M6: begin
				cmd.vert_ld  = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = bcp_pkg::MUL_TD;
				cmd.acc_mode = bcp_pkg::ACC_LOAD;
				state_d      = ST_M7;
			end
			ST_M7: begin
				cmd.acc_mode = bcp_pkg::ACC_ADD;
				state_d      = ST_TURN;
			end
			ST_TURN: begin
				cmd.turn_ld = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/bcp_dpath.sv */
// bcp_dpath: datapath of the cascaded balance controller
// config registers, loop state, shared 32x25 multiplier with accumulator, output register
// depends on bcp_pkg
module bcp_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bcp_pkg::dp_cmd_t                    cmd,
	output bcp_pkg::dp_status_t                 status,
	input  logic [bcp_pkg::IN_DATA_W-1:0]       in_data,
	input  logic [1:0]                          in_user,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bcp_pkg::OUT_DATA_W-1:0]      out_data,
	input  logic                                cfg_wr,
	input  logic [bcp_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [bcp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	// reciprocal of ten scaled by 2^24, rounded down
	localparam logic signed [31:0] DIV10_MUL = 32'sd1677721;
	localparam logic signed [18:0] INT_MAX   = 19'sd20000;
	localparam logic signed [18:0] INT_MIN   = -19'sd20000;

	function automatic logic signed [41:0] trunc_q16(input logic signed [57:0] x);
		logic signed [41:0] t;
		t = x[57:16];
		if (x[57] && (x[15:0] != 16'd0)) begin
			t = t + 42'sd1;
		end
		return t;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [42:0] x);
		logic signed [15:0] r;
		if (x > 43'sd32767) begin
			r = 16'sh7fff;
		end else if (x < -43'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = x[15:0];
		end
		return r;
	endfunction

	// config registers
	logic signed [15:0] balance_angle_q;
	logic signed [31:0] vp_gain_q;
	logic signed [31:0] vd_gain_q;
	logic signed [31:0] sp_gain_q;
	logic signed [31:0] si_gain_q;
	logic signed [31:0] tp_gain_q;
	logic signed [31:0] td_gain_q;
	logic signed [15:0] heading_q;

	// captured transaction
	logic [1:0]         command_q;
	logic signed [10:0] tspeed_q;
	logic signed [15:0] enc_l_q;
	logic signed [15:0] enc_r_q;
	logic signed [15:0] roll_q;
	logic signed [15:0] yaw_q;
	logic signed [15:0] gx_q;
	logic signed [15:0] gz_q;

	// loop state and working registers
	logic signed [17:0] fe_q;
	logic signed [15:0] is_q;
	logic signed [20:0] num_q;
	logic signed [56:0] prod_q;
	logic signed [57:0] acc_q;
	logic signed [15:0] vel_q;
	logic signed [24:0] diff_q;
	logic signed [41:0] vert_q;
	logic signed [41:0] turn_q;
	logic [bcp_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                           out_valid_q;

	logic signed [17:0] err;
	logic signed [20:0] num_d;
	logic [19:0]        num_abs;
	logic signed [31:0] mul_a;
	logic signed [24:0] mul_b;
	logic [16:0]        q0;
	logic [20:0]        ten_q0;
	logic [20:0]        rem;
	logic [17:0]        q1;
	logic signed [17:0] filt;
	logic signed [18:0] isum;
	logic signed [15:0] is_sat;
	logic signed [23:0] setp;
	logic signed [15:0] duty_l;
	logic signed [15:0] duty_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			balance_angle_q <= bcp_pkg::RST_BALANCE_ANGLE;
			vp_gain_q       <= bcp_pkg::RST_VERTICAL_P_GAIN;
			vd_gain_q       <= bcp_pkg::RST_VERTICAL_D_GAIN;
			sp_gain_q       <= bcp_pkg::RST_SPEED_P_GAIN;
			si_gain_q       <= bcp_pkg::RST_SPEED_I_GAIN;
			tp_gain_q       <= bcp_pkg::RST_TURN_P_GAIN;
			td_gain_q       <= bcp_pkg::RST_TURN_D_GAIN;
			heading_q       <= bcp_pkg::RST_TARGET_HEADING;
		end else if (cfg_wr) begin
			case (cfg_idx)
				bcp_pkg::REG_BALANCE_ANGLE:   balance_angle_q <= cfg_wdata[15:0];
				bcp_pkg::REG_VERTICAL_P_GAIN: vp_gain_q       <= cfg_wdata;
				bcp_pkg::REG_VERTICAL_D_GAIN: vd_gain_q       <= cfg_wdata;
				bcp_pkg::REG_SPEED_P_GAIN:    sp_gain_q       <= cfg_wdata;
				bcp_pkg::REG_SPEED_I_GAIN:    si_gain_q       <= cfg_wdata;
				bcp_pkg::REG_TURN_P_GAIN:     tp_gain_q       <= cfg_wdata;
				bcp_pkg::REG_TURN_D_GAIN:     td_gain_q       <= cfg_wdata;
				bcp_pkg::REG_TARGET_HEADING:  heading_q       <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			command_q <= in_user;
			tspeed_q  <= in_data[10:0];
			enc_l_q   <= in_data[26:11];
			enc_r_q   <= in_data[42:27];
			roll_q    <= in_data[58:43];
			yaw_q     <= in_data[74:59];
			gx_q      <= in_data[90:75];
			gz_q      <= in_data[106:91];
		end
	end

	// speed error and 3*err + 7*filtered
	assign err   = 18'(enc_l_q) - 18'(enc_r_q) - 18'(tspeed_q);
	assign num_d = (21'(err) <<< 1) + 21'(err) + (21'(fe_q) <<< 3) - 21'(fe_q);
	assign num_abs = num_q[20] ? 20'(-num_q) : num_q[19:0];

	always_comb begin
		case (cmd.mul_sel)
			bcp_pkg::MUL_DIV: begin
				mul_a = DIV10_MUL;
				mul_b = $signed({5'd0, num_abs});
			end
			bcp_pkg::MUL_SP: begin
				mul_a = sp_gain_q;
				mul_b = 25'(fe_q);
			end
			bcp_pkg::MUL_SI: begin
				mul_a = si_gain_q;
				mul_b = 25'(is_q);
			end
			bcp_pkg::MUL_VP: begin
				mul_a = vp_gain_q;
				mul_b = diff_q;
			end
			bcp_pkg::MUL_VD: begin
				mul_a = vd_gain_q;
				mul_b = 25'(gx_q);
			end
			bcp_pkg::MUL_TP: begin
				mul_a = tp_gain_q;
				mul_b = 25'(heading_q) - 25'(yaw_q);
			end
			bcp_pkg::MUL_TD: begin
				mul_a = td_gain_q;
				mul_b = 25'(gz_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divide by ten: reciprocal estimate is low by at most one
	assign q0     = prod_q[40:24];
	assign ten_q0 = 21'({q0, 3'd0}) + 21'({q0, 1'b0});
	assign rem    = 21'(num_abs) - ten_q0;
	assign q1     = 18'(q0) + ((rem >= 21'd10) ? 18'd1 : 18'd0);
	assign filt   = num_q[20] ? -$signed(q1) : $signed(q1);

	assign isum = 19'(is_q) + 19'(fe_q);
	always_comb begin
		if (isum > INT_MAX) begin
			is_sat = 16'(INT_MAX);
		end else if (isum < INT_MIN) begin
			is_sat = 16'(INT_MIN);
		end else begin
			is_sat = isum[15:0];
		end
	end

	assign setp   = (24'(vel_q) <<< 7) + 24'(balance_angle_q);
	assign duty_l = sat16(43'(vert_q) - 43'(turn_q));
	assign duty_r = sat16(43'(vert_q) + 43'(turn_q));

	always_ff @(posedge clk) begin
		if (cmd.num_ld) begin
			num_q <= num_d;
		end
		if (cmd.mul_en) begin
			prod_q <= 57'(mul_a) * 57'(mul_b);
		end
		case (cmd.acc_mode)
			bcp_pkg::ACC_LOAD: acc_q <= 58'(prod_q);
			bcp_pkg::ACC_ADD:  acc_q <= acc_q + 58'(prod_q);
			default: begin
			end
		endcase
		if (cmd.vel_ld) begin
			vel_q <= sat16(43'(trunc_q16(acc_q)));
		end
		if (cmd.diff_ld) begin
			diff_q <= 25'(roll_q) - 25'(setp);
		end
		if (cmd.vert_ld) begin
			vert_q <= trunc_q16(acc_q);
		end
		if (cmd.turn_ld) begin
			turn_q <= trunc_q16(acc_q);
		end
		if (cmd.out_ld) begin
			if (command_q == bcp_pkg::CMD_STOP) begin
				out_data_q <= '0;
			end else begin
				out_data_q <= {duty_r, duty_l};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q        <= '0;
			is_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fe_ld) begin
				fe_q <= filt;
			end
			if (cmd.is_clr) begin
				is_q <= '0;
			end else if (cmd.is_ld) begin
				is_q <= is_sat;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_data_q;
	assign status.command  = command_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

/* rtl/core/balance_cascade_pid.sv */
// balance_cascade_pid: top level of the cascaded balance controller
// joins the sequencer and the datapath, ties off the config channel ready
// depends on bcp_pkg, bcp_ctrl, bcp_dpath
//
// One control tick is one input transaction. The block takes one tick at a time: a run
// tick is accepted, walked through a single shared 32x25 multiplier and accumulator by the
// sequencer (speed filter with divide by ten, clamped integral, velocity PI, vertical PD,
// turn PD), and its duties land in the output register; the input is not ready again until
// they have been loaded. A stop tick goes straight from decode to the output state, gives
// zero duties and clears the integral; an idle tick gives no result and frees the input
// after its decode. The output register holds a result while the next tick is computed;
// a tick finishing into a full output register waits there. Config writes are taken at
// any time and must only be issued while no tick is in flight.
module balance_cascade_pid (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// speed_demand, encoder_left, encoder_right, roll_angle, yaw_angle, gyro_x, gyro_z
	input  logic [bcp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// command
	input  logic [1:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// duty_left, duty_right
	output logic [bcp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bcp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bcp_pkg::CFG_DATA_W-1:0]      cfg_data
);

	bcp_pkg::dp_cmd_t    cmd;
	bcp_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	bcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.status   (status)
	);

	bcp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data)
	);

endmodule

/* rtl/core/bcp_checker.sv */
// bcp_checker: port-level checks of the cascaded balance controller
// bound to balance_cascade_pid; depends on bcp_pkg
module bcp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [1:0] s_axis_tuser,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready
);

	// result held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped before transaction");

	// one tick at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while tick in flight");

	// a new result only comes out of a busy sequencer
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without tick in flight");

	// idle command gives no result
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser != bcp_pkg::CMD_RUN
		&& s_axis_tuser != bcp_pkg::CMD_STOP |-> ##3 !$rose(m_axis_tvalid))
		else $error("result from idle tick");

endmodule

bind balance_cascade_pid bcp_checker u_bcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
